[rtl/seven_segment_frame_sender_macros.svh]
`ifndef SEVEN_SEGMENT_FRAME_SENDER_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_SENDER_MACROS_SVH

// Check a property on every rising edge, out of reset.
`define SSFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define SSFS_ASSERT_NEVER(name, cond, msg) `SSFS_ASSERT(name, !(cond), msg)

`endif

[rtl/ssfs_pkg.sv]
package ssfs_pkg;

  localparam int DIGIT_COUNT    = 4;
  localparam int DIG_W          = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int VALUE_W        = 14;
  localparam int BYTE_COUNT_MAX = DIGIT_COUNT + 3;
  localparam int POS_W          = $clog2(BYTE_COUNT_MAX);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h88;

  localparam logic [CFG_IDX_W-1:0] CFG_TWO_DIGIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 2'd1;

  typedef logic [6:0] seg_t;
  typedef seg_t [DIGIT_COUNT-1:0] seg_vec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Segment a in bit 0 through segment g in bit 6.
  function automatic seg_t seg_code(input logic [3:0] digit);
    seg_t code;
    unique case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

[rtl/seven_segment_frame_sender.sv]
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+------------------------------------
// input    | in        | push / full                 | value_i[13:0]
// result   | out       | empty / pop                 | frame_byte_o, start_before_o,
//          |           |                             | stop_after_o, last_o
// config   | in        | cfg_valid_i / cfg_ready_o   | cfg_index_i[1:0], cfg_data_i[7:0]
//
// Each value yields 7 request bytes (5 in two-digit mode), one per cycle out of the
// result register while pop keeps that register drained.
// The digit splitter holds full high after a value (one divide-by-ten step per digit,
// the last also handing off, and held while the queue is full), so it takes no new value
// until the split is handed off; a two-entry queue sits between it and the byte sequencer.
// A value's first result byte passes the split steps, the queue and the result register.
// Reset clears all control state; two_digit_mode returns to 0 and brightness to 1.
// Low pop holds the result register, the queue then fills and full goes high.
module seven_segment_frame_sender import ssfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // value requests
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_W-1:0]    value_i,
  // frame bytes
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            frame_byte_o,
  output logic                  start_before_o,
  output logic                  stop_after_o,
  output logic                  last_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic       two_digit_mode_q;
  logic [2:0] brightness_q;

  q_stat_t    q_stat;
  logic       q_push;
  logic       q_pop;
  seg_vec_t   q_wdata;
  seg_vec_t   q_rdata;

  // Writes always land at once; unknown indexes drop silently.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_digit_mode_q <= 1'b0;
      brightness_q     <= 3'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TWO_DIGIT_MODE: two_digit_mode_q <= cfg_data_i[0];
        CFG_BRIGHTNESS:     brightness_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Front: accept a value and split it into segment codes.
  ssfs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Decouple splitting from byte emission.
  ssfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // Back: walk the frame, one byte per cycle into the result register while it drains.
  ssfs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .two_digit_mode_i (two_digit_mode_q),
    .brightness_i     (brightness_q),
    .pop              (pop),
    .empty            (empty),
    .frame_byte_o     (frame_byte_o),
    .start_before_o   (start_before_o),
    .stop_after_o     (stop_after_o),
    .last_o           (last_o)
  );

endmodule

[rtl/ssfs_front.sv]
`include "seven_segment_frame_sender_macros.svh"

module ssfs_front import ssfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] value_i,
  input  q_stat_t            q_stat_i,
  output logic               q_push_o,
  output seg_vec_t           q_data_o
);

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_SPLIT = 2'b10
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [VALUE_W-1:0] n_q, n_d;
  logic [DIG_W-1:0]   cnt_q, cnt_d;
  seg_vec_t           seg_q, seg_d;

  logic [29:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem;
  seg_t               cur_seg;
  logic               last_step;

  // Divide by ten: multiply by 2^19/10 rounded up, exact below 2^14.
  assign prod    = 30'(n_q) * 30'd52429;
  assign quot    = VALUE_W'(prod >> 19);
  assign rem     = n_q - (quot << 3) - (quot << 1);
  assign cur_seg = seg_code(rem[3:0]);

  assign full      = (state_q != F_IDLE);
  assign last_step = (state_q == F_SPLIT) && (cnt_q == '0);
  assign q_push_o  = last_step && !q_stat_i.full;

  always_comb begin
    q_data_o    = seg_q;
    q_data_o[0] = cur_seg;
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    seg_d   = seg_q;
    unique case (state_q)
      F_IDLE: begin
        if (push) begin
          n_d     = value_i;
          cnt_d   = DIG_W'(DIGIT_COUNT - 1);
          state_d = F_SPLIT;
        end
      end
      F_SPLIT: begin
        if (cnt_q != '0) begin
          seg_d[cnt_q] = cur_seg;
          n_d          = quot;
          cnt_d        = cnt_q - 1'b1;
        end else if (!q_stat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    seg_q <= seg_d;
  end

  `SSFS_ASSERT(a_push_on_last_step, q_push_o |-> (state_q == F_SPLIT) && (cnt_q == '0), "push outside last split step")
  `SSFS_ASSERT(a_idle_after_push, q_push_o |=> (state_q == F_IDLE), "front not idle after push")

endmodule

[rtl/ssfs_queue.sv]
`include "seven_segment_frame_sender_macros.svh"

module ssfs_queue import ssfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seg_vec_t data_i,
  input  logic     pop_i,
  output seg_vec_t data_o,
  output q_stat_t  stat_o
);

  seg_vec_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SSFS_ASSERT_NEVER(a_no_pop_when_empty, pop_i && (cnt_q == '0), "pop from empty queue")
  `SSFS_ASSERT(a_count_bounded, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

[rtl/ssfs_back.sv]
`include "seven_segment_frame_sender_macros.svh"

module ssfs_back import ssfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_stat_t    q_stat_i,
  input  seg_vec_t   q_data_i,
  output logic       q_pop_o,
  input  logic       two_digit_mode_i,
  input  logic [2:0] brightness_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] frame_byte_o,
  output logic       start_before_o,
  output logic       stop_after_o,
  output logic       last_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             valid_q, valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             st_q, st_d, sp_q, sp_d, last_q, last_d;

  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] seg_pos;
  logic [DIG_W-1:0] seg_idx;
  logic             slot_free, go, at_last;

  assign last_pos  = two_digit_mode_i ? POS_W'(4) : POS_W'(BYTE_COUNT_MAX - 1);
  assign first_pos = two_digit_mode_i ? POS_W'(DIGIT_COUNT - 2) : '0;
  assign seg_pos   = first_pos + pos_q - POS_W'(2);
  assign seg_idx   = seg_pos[DIG_W-1:0];

  // Advance whenever the queue holds a value and the result register is empty or being drained.
  assign slot_free = !valid_q || pop;
  assign go        = slot_free && !q_stat_i.empty;
  assign at_last   = (pos_q == last_pos);
  assign q_pop_o   = go && at_last;

  always_comb begin
    byte_d = byte_q;
    st_d   = st_q;
    sp_d   = sp_q;
    last_d = last_q;
    if (go) begin
      priority if (pos_q == '0) begin
        byte_d = CMD_DATA;
        st_d   = 1'b1;
        sp_d   = 1'b1;
        last_d = 1'b0;
      end else if (pos_q == POS_W'(1)) begin
        byte_d = CMD_ADDR;
        st_d   = 1'b1;
        sp_d   = 1'b0;
        last_d = 1'b0;
      end else if (at_last) begin
        byte_d = CMD_CTRL + {5'b0, brightness_i};
        st_d   = 1'b1;
        sp_d   = 1'b1;
        last_d = 1'b1;
      end else begin
        byte_d = {1'b0, q_data_i[seg_idx]};
        st_d   = 1'b0;
        sp_d   = (seg_idx == DIG_W'(DIGIT_COUNT - 1));
        last_d = 1'b0;
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (go) begin
      pos_d   = at_last ? '0 : pos_q + 1'b1;
      valid_d = 1'b1;
    end else if (pop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    st_q   <= st_d;
    sp_q   <= sp_d;
    last_q <= last_d;
  end

  assign empty          = !valid_q;
  assign frame_byte_o   = byte_q;
  assign start_before_o = st_q;
  assign stop_after_o   = sp_q;
  assign last_o         = last_q;

  `SSFS_ASSERT(a_pos_in_range, pos_q <= last_pos, "byte position out of range")
  `SSFS_ASSERT(a_last_is_own_frame, (valid_q && last_q) |-> (st_q && sp_q), "last byte not framed")

endmodule
